// ----- src/b2r_pkg.sv -----
// shared types, constants and digit helpers for the roman numeral converter
package b2r_pkg;

    localparam logic [11:0] ROMAN_MAX = 12'd3999;

    localparam logic [6:0] CH_M = 7'h4D;
    localparam logic [6:0] CH_D = 7'h44;
    localparam logic [6:0] CH_C = 7'h43;
    localparam logic [6:0] CH_L = 7'h4C;
    localparam logic [6:0] CH_X = 7'h58;
    localparam logic [6:0] CH_V = 7'h56;
    localparam logic [6:0] CH_I = 7'h49;
    localparam logic [6:0] CH_NONE = 7'h00;

    localparam logic [1:0] POS_THOU  = 2'd0;
    localparam logic [1:0] POS_HUND  = 2'd1;
    localparam logic [1:0] POS_TENS  = 2'd2;
    localparam logic [1:0] POS_UNITS = 2'd3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic       is_zero;
        logic       is_err;
        logic [1:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } t_ent;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_back_state;

    function automatic logic [3:0] f_digit(input t_ent e, input logic [1:0] pos);
        logic [3:0] d;
        case (pos)
            POS_THOU: d = {2'b00, e.thou};
            POS_HUND: d = e.hund;
            POS_TENS: d = e.tens;
            default:  d = e.units;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] f_len(input logic [3:0] d);
        logic [2:0] n;
        case (d)
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [6:0] f_sym(input logic [1:0] pos, input logic [3:0] d,
                                         input logic [1:0] k);
        logic [6:0] one;
        logic [6:0] five;
        logic [6:0] ten;
        logic [6:0] ch;
        case (pos)
            POS_THOU: begin
                one = CH_M; five = CH_NONE; ten = CH_NONE;
            end
            POS_HUND: begin
                one = CH_C; five = CH_D; ten = CH_M;
            end
            POS_TENS: begin
                one = CH_X; five = CH_L; ten = CH_C;
            end
            default: begin
                one = CH_I; five = CH_V; ten = CH_X;
            end
        endcase
        if (d == 4'd9) begin
            ch = (k == 2'd0) ? one : ten;
        end else if (d == 4'd4) begin
            ch = (k == 2'd0) ? one : five;
        end else if (d >= 4'd5) begin
            ch = (k == 2'd0) ? five : one;
        end else begin
            ch = one;
        end
        return ch;
    endfunction

    function automatic logic [1:0] f_first(input t_ent e);
        logic [1:0] pos;
        pos = POS_UNITS;
        for (int p = 3; p >= 0; p--) begin
            if (f_len(f_digit(e, 2'(p))) != 3'd0) begin
                pos = 2'(p);
            end
        end
        return pos;
    endfunction

    function automatic logic f_has_after(input t_ent e, input logic [1:0] pos);
        logic found;
        found = 1'b0;
        for (int p = 0; p < 4; p++) begin
            if (2'(p) > pos && f_len(f_digit(e, 2'(p))) != 3'd0) begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic logic [1:0] f_next_pos(input t_ent e, input logic [1:0] pos);
        logic [1:0] nxt;
        nxt = POS_UNITS;
        for (int p = 3; p >= 0; p--) begin
            if (2'(p) > pos && f_len(f_digit(e, 2'(p))) != 3'd0) begin
                nxt = 2'(p);
            end
        end
        return nxt;
    endfunction

endpackage

// ----- src/binary_to_roman_numeral.sv -----
// top level of the binary to roman numeral converter
//
// usage:
//   slave channel takes one 12-bit binary value per transaction in tdata
//   master channel returns the numeral one ascii character per transaction,
//   tlast on the final character; tuser flags zero (empty) and out-of-range
//   values, each of which gives a single transaction with symbol 0
// flow:
//   the front end splits a value into decimal digits: thousands, then
//   hundreds, then tens and units together; a zero or out-of-range value
//   skips these steps; it then hands the value through a two-entry queue
//   to the back end, which emits one character per cycle while tready is
//   high and a value is waiting, 1 to 15 per value (15 for 3888); the front
//   end can take the next value while the back end still emits the last one
//   the back end registers the first character as it takes a value from the queue
// reset: synchronous active-low reset empties the queue and drops any
//   pending output; no clearing pass is needed
// stall: a low tready holds the current character in the output register;
//   the back end, then the queue, then the front end fill up and the slave
//   tready stays low
module binary_to_roman_numeral (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] value, [15:12] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [6:0] symbol, [7] zero
    output logic        o_m_axis_tlast,
    output logic [1:0]  o_m_axis_tuser    // [0] empty_res, [1] range_error
);

    logic          push;
    logic          full;
    logic          pop;
    logic          q_valid;
    b2r_pkg::t_ent f_ent;
    b2r_pkg::t_ent q_ent;
    logic [6:0]    symbol;
    logic          empty_res;
    logic          range_error;

    b2r_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_value (i_s_axis_tdata[11:0]),
        .o_push  (push),
        .o_ent   (f_ent),
        .i_full  (full)
    );

    b2r_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (f_ent),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    b2r_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_ent         (q_ent),
        .o_pop         (pop),
        .o_tvalid      (o_m_axis_tvalid),
        .i_tready      (i_m_axis_tready),
        .o_symbol      (symbol),
        .o_last        (o_m_axis_tlast),
        .o_empty_res   (empty_res),
        .o_range_error (range_error)
    );

    assign o_m_axis_tdata = {1'b0, symbol};
    assign o_m_axis_tuser = {range_error, empty_res};

endmodule

// ----- src/b2r_front.sv -----
// front end: accepts a value, classifies it and splits it into decimal digits
module b2r_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [11:0]       i_value,
    output logic              o_push,
    output b2r_pkg::t_ent     o_ent,
    input  logic              i_full
);

    b2r_pkg::t_front_state r_state, n_state;
    logic [11:0]           r_rem, n_rem;
    logic [1:0]            r_step, n_step;
    b2r_pkg::t_ent         r_ent, n_ent;

    logic [13:0] weight;
    logic [3:0]  digit;
    logic [13:0] sub;

    always_comb begin
        case (r_step)
            2'd0:    weight = 14'd1000;
            2'd1:    weight = 14'd100;
            default: weight = 14'd10;
        endcase
        digit = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, r_rem} >= 14'(k) * weight) begin
                digit = 4'(k);
            end
        end
        sub = 14'(digit) * weight;
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_step  = r_step;
        n_ent   = r_ent;
        o_ready = (r_state == b2r_pkg::F_IDLE);
        o_push  = 1'b0;
        case (r_state)
            b2r_pkg::F_IDLE: begin
                if (i_valid) begin
                    n_rem         = i_value;
                    n_step        = 2'd0;
                    n_ent         = '0;
                    n_ent.is_zero = (i_value == 12'd0);
                    n_ent.is_err  = (i_value > b2r_pkg::ROMAN_MAX);
                    if (i_value == 12'd0 || i_value > b2r_pkg::ROMAN_MAX) begin
                        n_state = b2r_pkg::F_PUSH;
                    end else begin
                        n_state = b2r_pkg::F_CONV;
                    end
                end
            end
            b2r_pkg::F_CONV: begin
                n_rem  = 12'({2'b00, r_rem} - sub);
                n_step = r_step + 2'd1;
                case (r_step)
                    2'd0: n_ent.thou = digit[1:0];
                    2'd1: n_ent.hund = digit;
                    default: begin
                        n_ent.tens  = digit;
                        n_ent.units = n_rem[3:0];
                        n_state     = b2r_pkg::F_PUSH;
                    end
                endcase
            end
            b2r_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = b2r_pkg::F_IDLE;
                end
            end
            default: n_state = b2r_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2r_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem  <= n_rem;
        r_step <= n_step;
        r_ent  <= n_ent;
    end

    assign o_ent = r_ent;

endmodule

// ----- src/b2r_queue.sv -----
// short queue of classified digit sets between front and back
module b2r_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  b2r_pkg::t_ent i_ent,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output b2r_pkg::t_ent o_ent
);

    b2r_pkg::t_ent                 r_mem [b2r_pkg::Q_DEPTH];
    logic [b2r_pkg::Q_PTR_W-1:0]   r_wr, n_wr;
    logic [b2r_pkg::Q_PTR_W-1:0]   r_rd, n_rd;
    logic [b2r_pkg::Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_cnt == b2r_pkg::Q_CNT_W'(b2r_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == b2r_pkg::Q_PTR_W'(b2r_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == b2r_pkg::Q_PTR_W'(b2r_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

endmodule

// ----- src/b2r_back.sv -----
// back end: walks the digits and emits one numeral character per transaction
module b2r_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  b2r_pkg::t_ent i_ent,
    output logic          o_pop,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [6:0]    o_symbol,
    output logic          o_last,
    output logic          o_empty_res,
    output logic          o_range_error
);

    b2r_pkg::t_back_state r_state, n_state;
    b2r_pkg::t_ent        r_ent, n_ent;
    logic [1:0]           r_pos, n_pos;
    logic [1:0]           r_k, n_k;
    logic                 r_valid, n_valid;
    logic [6:0]           r_sym, n_sym;
    logic                 r_last, n_last;
    logic                 r_empty, n_empty;
    logic                 r_err, n_err;

    logic          idle;
    logic          out_free;
    logic          fire;
    b2r_pkg::t_ent cur;
    logic [1:0]    cur_pos;
    logic [1:0]    cur_k;
    logic [3:0]    d;
    logic [2:0]    n;
    logic          eod;
    logic          has;
    logic          special;
    logic [6:0]    e_sym;
    logic          e_last;

    always_comb begin
        idle     = (r_state == b2r_pkg::B_IDLE);
        out_free = !r_valid || i_tready;
        cur      = idle ? i_ent : r_ent;
        cur_pos  = idle ? b2r_pkg::f_first(i_ent) : r_pos;
        cur_k    = idle ? 2'd0 : r_k;
        fire     = (idle ? i_valid : 1'b1) && out_free;
        o_pop    = idle && i_valid && out_free;
        d        = b2r_pkg::f_digit(cur, cur_pos);
        n        = b2r_pkg::f_len(d);
        eod      = ({1'b0, cur_k} == (n - 3'd1));
        has      = b2r_pkg::f_has_after(cur, cur_pos);
        special  = cur.is_zero || cur.is_err;
        e_sym    = special ? b2r_pkg::CH_NONE : b2r_pkg::f_sym(cur_pos, d, cur_k);
        e_last   = special || (eod && !has);

        n_state = r_state;
        n_ent   = r_ent;
        n_pos   = r_pos;
        n_k     = r_k;
        n_valid = r_valid;
        n_sym   = r_sym;
        n_last  = r_last;
        n_empty = r_empty;
        n_err   = r_err;
        if (fire) begin
            n_ent   = cur;
            n_valid = 1'b1;
            n_sym   = e_sym;
            n_last  = e_last;
            n_empty = cur.is_zero;
            n_err   = cur.is_err;
            if (e_last) begin
                n_state = b2r_pkg::B_IDLE;
            end else begin
                n_state = b2r_pkg::B_RUN;
            end
            if (eod) begin
                n_pos = b2r_pkg::f_next_pos(cur, cur_pos);
                n_k   = 2'd0;
            end else begin
                n_pos = cur_pos;
                n_k   = cur_k + 2'd1;
            end
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2r_pkg::B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_ent   <= n_ent;
        r_pos   <= n_pos;
        r_k     <= n_k;
        r_sym   <= n_sym;
        r_last  <= n_last;
        r_empty <= n_empty;
        r_err   <= n_err;
    end

    assign o_tvalid      = r_valid;
    assign o_symbol      = r_sym;
    assign o_last        = r_last;
    assign o_empty_res   = r_empty;
    assign o_range_error = r_err;

endmodule

// ----- bench/tb_binary_to_roman_numeral.sv -----
// self-checking testbench for the binary to roman numeral converter
module tb_binary_to_roman_numeral;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] symbol;
        logic       last;
        logic       empty_res;
        logic       range_error;
    } t_numeral_char;

    typedef enum logic {
        ROW_PREDICT,
        ROW_FIXED
    } t_row_kind;

    typedef struct packed {
        logic [11:0]   value;
        t_row_kind     kind;
        t_numeral_char fixed;
    } t_value_row;

    localparam int N_RANDOM   = 425;
    localparam int DRAIN_WAIT = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [15:0] i_s_axis_tdata = '0;   // [11:0] value, [15:12] zero
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;        // [6:0] symbol, [7] zero
    logic        o_m_axis_tlast;
    logic [1:0]  o_m_axis_tuser;        // [0] empty_res, [1] range_error

    t_numeral_char pending_chars[$];
    t_numeral_char want_char;
    t_value_row    value_rows[$];

    int  err_count = 0;
    int  values_sent = 0;
    int  zero_values = 0;
    int  range_values = 0;
    int  chars_checked = 0;
    int  stall_left = 0;
    bit  src_idle_on = 1'b1;
    bit  snk_stall_on = 1'b1;

    binary_to_roman_numeral i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic t_numeral_char make_char(logic [6:0] sym, logic last,
                                                logic empty, logic rerr);
        t_numeral_char c;
        c.symbol      = sym;
        c.last        = last;
        c.empty_res   = empty;
        c.range_error = rerr;
        return c;
    endfunction

    // builds the numeral digit by digit in subtractive form
    function automatic void predict_numeral(input logic [11:0] value);
        logic [6:0] one_ch[4];
        logic [6:0] five_ch[4];
        logic [6:0] ten_ch[4];
        logic [6:0] chars[$];
        int         digit[4];
        int         d;
        int         v;
        v = int'(value);
        if (v == 0) begin
            pending_chars.push_back(make_char(b2r_pkg::CH_NONE, 1'b1, 1'b1, 1'b0));
            return;
        end
        if (value > b2r_pkg::ROMAN_MAX) begin
            pending_chars.push_back(make_char(b2r_pkg::CH_NONE, 1'b1, 1'b0, 1'b1));
            return;
        end
        one_ch  = '{b2r_pkg::CH_M, b2r_pkg::CH_C, b2r_pkg::CH_X, b2r_pkg::CH_I};
        five_ch = '{b2r_pkg::CH_NONE, b2r_pkg::CH_D, b2r_pkg::CH_L, b2r_pkg::CH_V};
        ten_ch  = '{b2r_pkg::CH_NONE, b2r_pkg::CH_M, b2r_pkg::CH_C, b2r_pkg::CH_X};
        digit   = '{v / 1000, (v / 100) % 10, (v / 10) % 10, v % 10};
        for (int i = 0; i < digit[0]; i++) begin
            chars.push_back(b2r_pkg::CH_M);
        end
        for (int p = 1; p < 4; p++) begin
            d = digit[p];
            if (d == 9) begin
                chars.push_back(one_ch[p]);
                chars.push_back(ten_ch[p]);
            end else if (d == 4) begin
                chars.push_back(one_ch[p]);
                chars.push_back(five_ch[p]);
            end else begin
                if (d >= 5) begin
                    chars.push_back(five_ch[p]);
                    d -= 5;
                end
                for (int i = 0; i < d; i++) begin
                    chars.push_back(one_ch[p]);
                end
            end
        end
        foreach (chars[i]) begin
            pending_chars.push_back(make_char(chars[i], i == chars.size() - 1, 1'b0, 1'b0));
        end
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        err_count++;
        $display("%0t: %s got 0x%0h, want 0x%0h", $time, field, got, want);
    endtask

    // called just after a rising edge; returns at the edge of acceptance
    task automatic send_value(input t_value_row row);
        int gap;
        gap = src_idle_on ? (($urandom_range(0, 99) < 60) ? 0 : pick_gap()) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, row.value};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (row.kind == ROW_FIXED) begin
            pending_chars.push_back(row.fixed);
        end else begin
            predict_numeral(row.value);
        end
        values_sent++;
        if (row.value == 12'd0) begin
            zero_values++;
        end else if (row.value > b2r_pkg::ROMAN_MAX) begin
            range_values++;
        end
    endtask

    task automatic hold_until_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_value_row predict_row(input logic [11:0] value);
        t_value_row r;
        r.value = value;
        r.kind  = ROW_PREDICT;
        r.fixed = '0;
        return r;
    endfunction

    function automatic logic [11:0] random_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return 12'd0;
        end else if (pick < 12) begin
            return 12'($urandom_range(4000, 4095));
        end else if (pick < 22) begin
            // long numerals: 1 to 3 thousands plus 777 or 888, sometimes minus 4
            return 12'($urandom_range(1, 3) * 1000 + 111 * (($urandom_range(0, 1) == 0) ? 7 : 8)
                       - (($urandom_range(0, 1) == 0) ? 0 : 4 * $urandom_range(0, 1)));
        end else if (pick < 40) begin
            return 12'($urandom_range(1, 99));
        end
        return 12'($urandom_range(1, 3999));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected transaction, tdata", o_m_axis_tdata, 0);
            end else begin
                want_char = pending_chars.pop_front();
                if (o_m_axis_tdata !== {1'b0, want_char.symbol}) begin
                    report_mismatch("symbol", o_m_axis_tdata, want_char.symbol);
                end
                if (o_m_axis_tlast !== want_char.last) begin
                    report_mismatch("last", o_m_axis_tlast, want_char.last);
                end
                if (o_m_axis_tuser[0] !== want_char.empty_res) begin
                    report_mismatch("empty_res", o_m_axis_tuser[0], want_char.empty_res);
                end
                if (o_m_axis_tuser[1] !== want_char.range_error) begin
                    report_mismatch("range_error", o_m_axis_tuser[1], want_char.range_error);
                end
            end
        end
        if (snk_stall_on && stall_left == 0 && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #20_000_000;
        $display("binary_to_roman_numeral: mismatch");
        $finish;
    end

    initial begin
        value_rows = '{
            '{12'd0,    ROW_FIXED,   '{b2r_pkg::CH_NONE, 1'b1, 1'b1, 1'b0}},
            '{12'd4000, ROW_FIXED,   '{b2r_pkg::CH_NONE, 1'b1, 1'b0, 1'b1}},
            '{12'd4095, ROW_FIXED,   '{b2r_pkg::CH_NONE, 1'b1, 1'b0, 1'b1}},
            '{12'd1,    ROW_FIXED,   '{b2r_pkg::CH_I,    1'b1, 1'b0, 1'b0}},
            '{12'd3999, ROW_PREDICT, '0},
            '{12'd3888, ROW_PREDICT, '0},
            '{12'd4,    ROW_PREDICT, '0},
            '{12'd9,    ROW_PREDICT, '0},
            '{12'd40,   ROW_PREDICT, '0},
            '{12'd90,   ROW_PREDICT, '0},
            '{12'd400,  ROW_PREDICT, '0},
            '{12'd900,  ROW_PREDICT, '0},
            '{12'd5,    ROW_PREDICT, '0},
            '{12'd10,   ROW_PREDICT, '0},
            '{12'd50,   ROW_PREDICT, '0},
            '{12'd100,  ROW_PREDICT, '0},
            '{12'd500,  ROW_PREDICT, '0},
            '{12'd1000, ROW_PREDICT, '0},
            '{12'd45,   ROW_PREDICT, '0},
            '{12'd950,  ROW_PREDICT, '0},
            '{12'd1994, ROW_PREDICT, '0},
            '{12'd2048, ROW_PREDICT, '0},
            '{12'd3000, ROW_PREDICT, '0},
            '{12'd444,  ROW_PREDICT, '0},
            '{12'd999,  ROW_PREDICT, '0}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (value_rows[i]) begin
            send_value(value_rows[i]);
        end
        hold_until_drained();

        // quarters: no idling, sender gaps only, receiver stalls only, both
        for (int i = 0; i < N_RANDOM; i++) begin
            src_idle_on  = ((i * 4 / N_RANDOM) % 2) == 1;
            snk_stall_on = (i * 4 / N_RANDOM) >= 2;
            send_value(predict_row(random_value()));
            if (i == N_RANDOM / 2) begin
                hold_until_drained();
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d values (%0d zero, %0d out of range) with gaps and stalls",
                 values_sent, zero_values, range_values);
        $display("checked %0d numeral characters, %0d field errors", chars_checked, err_count);
        if (err_count == 0 && pending_chars.size() == 0) begin
            $display("binary_to_roman_numeral: match");
        end else begin
            $display("binary_to_roman_numeral: mismatch");
        end
        $finish;
    end

endmodule

// ----- binary_to_roman_numeral.f -----
src/b2r_pkg.sv
src/b2r_front.sv
src/b2r_queue.sv
src/b2r_back.sv
src/binary_to_roman_numeral.sv
bench/tb_binary_to_roman_numeral.sv
